// ----- src/contiguous_allocator_compaction_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the contiguous allocator
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_ALLOCATOR_COMPACTION_TOP_DEFINES_SVH
`define CONTIGUOUS_ALLOCATOR_COMPACTION_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Check an invariant on every clock edge outside reset.
`define CAC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: invariant");
// Check that an antecedent implies a consequence in the next cycle.
`define CAC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define CAC_ASSERT(name, clk, rst_n, prop)
`define CAC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/cac_pkg.sv -----
// ----------------------------------------------------------------------------
// cac_pkg
// Shared widths, codes and helpers of the contiguous allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cac_pkg;

  localparam int unsigned MEMORY_UNITS  = 1024;
  localparam int unsigned MAX_ENTRIES   = 512;
  localparam int unsigned RESERVE_RESET = 307;

  // Item field widths
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned POS_W    = 9;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ID_W     = 10;
  localparam int unsigned ADDR_W   = 11;
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned RSV_W    = 11;

  // Entry index into the stores, and the internal free pointer width.
  localparam int unsigned ENTRY_AW = $clog2(MAX_ENTRIES);
  localparam int unsigned PTR_W    = 12;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_COMPACT = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK          = 3'd0,
    STS_NO_MEM      = 3'd1,
    STS_NONE_ACTIVE = 3'd2,
    STS_BAD_POS     = 3'd3,
    STS_ID_FULL     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FREE_ID,
    ST_SHIFT,
    ST_LAST,
    ST_LAST_ID,
    ST_LAST_SUM,
    ST_COMPACT,
    ST_DONE
  } state_e;

  // Store entry of a region id; ids start at one.
  function automatic logic [ENTRY_AW-1:0] slot_of(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] dec;
    dec = id - ID_W'(1);
    if (id == '0 || id > ID_W'(MAX_ENTRIES)) begin
      return '0;
    end
    return dec[ENTRY_AW-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/cac_ram.sv -----
// ----------------------------------------------------------------------------
// cac_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cac_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned ADDR_W = 4
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/contiguous_allocator_compaction_top.sv -----
// Allocate, rejected, unknown and failed free items pass through ST_DECODE and ST_DONE to the result.
// A free goes through ST_FREE_ID, ST_SHIFT with one list shift per cycle while entries follow the
// victim, ST_LAST, ST_LAST_ID and ST_LAST_SUM; it skips the last two when it empties the list.
// Compact runs a 3-stage walk over the active list. Throughput: one item at a time; the next item is
// taken in the cycle after the result loads, while that result may still wait on out_stall_i.
// Reset: rst_ni clears control state, os_reserve and the free pointer return to 307;
// the two RAMs are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// contiguous_allocator_compaction_top
// Contiguous region allocator with free-by-position and compaction. The active
// list lives in one synchronous RAM; region sizes and starts share a second.
// ----------------------------------------------------------------------------
`default_nettype none

`include "contiguous_allocator_compaction_top_defines.svh"

module contiguous_allocator_compaction_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           os_reserve_we_i,
  input  wire logic [cac_pkg::RSV_W-1:0]      os_reserve_i,
  // command items
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [cac_pkg::CMD_W-1:0]      command_i,
  input  wire logic [cac_pkg::SIZE_W-1:0]     region_size_i,
  input  wire logic [cac_pkg::POS_W-1:0]      victim_position_i,
  // result items
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [cac_pkg::STATUS_W-1:0]   status_o,
  output logic      [cac_pkg::ID_W-1:0]       region_id_o,
  output logic      [cac_pkg::ADDR_W-1:0]     region_address_o,
  output logic      [cac_pkg::ADDR_W-1:0]     next_free_o,
  output logic      [cac_pkg::CNT_W-1:0]      active_count_o
);

  localparam int unsigned AW       = cac_pkg::ENTRY_AW;
  // Region entry: size in the upper bits, start in the lower bits.
  localparam int unsigned REGION_W = cac_pkg::SIZE_W + cac_pkg::PTR_W;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  cac_pkg::state_e state_q, state_d;

  // Accepted item
  cac_pkg::cmd_e                 cmd_q;
  logic [cac_pkg::SIZE_W-1:0]    size_q;
  logic [cac_pkg::POS_W-1:0]     pos_q;

  // Allocator state
  logic [cac_pkg::RSV_W-1:0]     reserve_q;
  logic [cac_pkg::CNT_W-1:0]     id_q, id_d;
  logic [cac_pkg::CNT_W-1:0]     live_q, live_d;
  logic [cac_pkg::PTR_W-1:0]     fp_q, fp_d;

  // Walk control for free shifts and compaction
  logic [cac_pkg::CNT_W-1:0]     idx_q, idx_d;
  logic [cac_pkg::PTR_W-1:0]     next_q, next_d;
  logic                          v1_q, v1_d;
  logic                          v2_q, v2_d;
  logic [AW-1:0]                 slot_q, slot_d;

  // Result under construction
  cac_pkg::status_e              res_status_q, res_status_d;
  logic [cac_pkg::ID_W-1:0]      res_id_q, res_id_d;
  logic [cac_pkg::ADDR_W-1:0]    res_addr_q, res_addr_d;

  // Output register
  logic                          out_valid_q;
  logic [cac_pkg::STATUS_W-1:0]  out_status_q;
  logic [cac_pkg::ID_W-1:0]      out_id_q;
  logic [cac_pkg::ADDR_W-1:0]    out_addr_q;
  logic [cac_pkg::ADDR_W-1:0]    out_free_q;
  logic [cac_pkg::CNT_W-1:0]     out_count_q;

  // --------------------------------------------------------------------------
  // RAM ports
  // --------------------------------------------------------------------------
  logic                          list_we;
  logic [AW-1:0]                 list_waddr, list_raddr;
  logic [cac_pkg::ID_W-1:0]      list_wdata, list_rdata;

  logic                          region_we;
  logic [AW-1:0]                 region_waddr, region_raddr;
  logic [REGION_W-1:0]           region_wdata, region_rdata;
  logic [cac_pkg::SIZE_W-1:0]    size_rdata;
  logic [cac_pkg::PTR_W-1:0]     start_rdata;

  // --------------------------------------------------------------------------
  // Shared datapath terms
  // --------------------------------------------------------------------------
  logic                          in_accept;
  logic                          load_out;
  logic [cac_pkg::PTR_W:0]       alloc_end;
  logic                          alloc_no_mem;
  logic                          alloc_full;
  logic [cac_pkg::CNT_W-1:0]     id_new;
  logic                          pos_bad;
  logic                          shift_more;
  logic                          walk_done;
  logic [AW-1:0]                 last_slot;

  assign in_stall_o = (state_q != cac_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign load_out   = (state_q == cac_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  // Allocate checks: memory end first, then the id store.
  assign alloc_end    = {1'b0, fp_q} + (cac_pkg::PTR_W + 1)'(size_q);
  assign alloc_no_mem = alloc_end > (cac_pkg::PTR_W + 1)'(cac_pkg::MEMORY_UNITS);
  assign alloc_full   = (id_q >= cac_pkg::CNT_W'(cac_pkg::MAX_ENTRIES)) ||
                        (live_q >= cac_pkg::CNT_W'(cac_pkg::MAX_ENTRIES));
  assign id_new       = id_q + cac_pkg::CNT_W'(1);

  assign pos_bad    = {1'b0, pos_q} >= live_q;
  // In the free walk idx_q points at the entry being overwritten.
  assign shift_more = (idx_q + cac_pkg::CNT_W'(1)) < live_q;
  assign walk_done  = (idx_q >= live_q) && !v1_q && !v2_q;
  assign last_slot  = cac_pkg::slot_of(list_rdata);

  assign {size_rdata, start_rdata} = region_rdata;

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      cac_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = cac_pkg::ST_DECODE;
        end
      end
      cac_pkg::ST_DECODE: begin
        case (cmd_q)
          cac_pkg::CMD_FREE: begin
            if (live_q == '0 || pos_bad) begin
              state_d = cac_pkg::ST_DONE;
            end else begin
              state_d = cac_pkg::ST_FREE_ID;
            end
          end
          cac_pkg::CMD_COMPACT: state_d = cac_pkg::ST_COMPACT;
          default:              state_d = cac_pkg::ST_DONE;
        endcase
      end
      cac_pkg::ST_FREE_ID: begin
        state_d = shift_more ? cac_pkg::ST_SHIFT : cac_pkg::ST_LAST;
      end
      cac_pkg::ST_SHIFT: begin
        // Leave once the entry just moved was the last one.
        if ((idx_q + cac_pkg::CNT_W'(2)) >= live_q) begin
          state_d = cac_pkg::ST_LAST;
        end
      end
      cac_pkg::ST_LAST: begin
        if (live_q == cac_pkg::CNT_W'(1)) begin
          state_d = cac_pkg::ST_DONE;
        end else begin
          state_d = cac_pkg::ST_LAST_ID;
        end
      end
      cac_pkg::ST_LAST_ID:  state_d = cac_pkg::ST_LAST_SUM;
      cac_pkg::ST_LAST_SUM: state_d = cac_pkg::ST_DONE;
      cac_pkg::ST_COMPACT: begin
        if (walk_done) begin
          state_d = cac_pkg::ST_DONE;
        end
      end
      cac_pkg::ST_DONE: begin
        if (load_out) begin
          state_d = cac_pkg::ST_IDLE;
        end
      end
      default: state_d = cac_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and RAM control
  // --------------------------------------------------------------------------
  always_comb begin
    id_d         = id_q;
    live_d       = live_q;
    fp_d         = fp_q;
    idx_d        = idx_q;
    next_d       = next_q;
    v1_d         = 1'b0;
    v2_d         = 1'b0;
    slot_d       = slot_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_addr_d   = res_addr_q;

    list_we      = 1'b0;
    list_waddr   = idx_q[AW-1:0];
    list_wdata   = list_rdata;
    list_raddr   = idx_q[AW-1:0];
    region_we    = 1'b0;
    region_waddr = id_q[AW-1:0];
    region_wdata = {size_q, fp_q};
    region_raddr = last_slot;

    case (state_q)
      cac_pkg::ST_DECODE: begin
        res_status_d = cac_pkg::STS_OK;
        res_id_d     = '0;
        res_addr_d   = '0;
        case (cmd_q)
          cac_pkg::CMD_ALLOC: begin
            if (alloc_no_mem) begin
              res_status_d = cac_pkg::STS_NO_MEM;
            end else if (alloc_full) begin
              res_status_d = cac_pkg::STS_ID_FULL;
            end else begin
              // Region with id k sits at store entry k-1, i.e. the old counter.
              region_we   = 1'b1;
              list_we     = 1'b1;
              list_waddr  = live_q[AW-1:0];
              list_wdata  = id_new;
              id_d        = id_new;
              live_d      = live_q + cac_pkg::CNT_W'(1);
              fp_d        = alloc_end[cac_pkg::PTR_W-1:0];
              res_id_d    = id_new;
              res_addr_d  = fp_q[cac_pkg::ADDR_W-1:0];
            end
          end
          cac_pkg::CMD_FREE: begin
            if (live_q == '0) begin
              fp_d         = cac_pkg::PTR_W'(reserve_q);
              res_status_d = cac_pkg::STS_NONE_ACTIVE;
            end else if (pos_bad) begin
              res_status_d = cac_pkg::STS_BAD_POS;
            end else begin
              list_raddr = pos_q;
              idx_d      = cac_pkg::CNT_W'(pos_q);
            end
          end
          cac_pkg::CMD_COMPACT: begin
            idx_d  = '0;
            next_d = cac_pkg::PTR_W'(reserve_q);
          end
          default: begin
          end
        endcase
      end

      cac_pkg::ST_FREE_ID: begin
        // Victim id is on the read port; prefetch its successor.
        res_id_d   = list_rdata;
        list_raddr = idx_q[AW-1:0] + AW'(1);
      end

      cac_pkg::ST_SHIFT: begin
        // Move entry idx+1 down to idx and fetch idx+2.
        list_we    = 1'b1;
        list_waddr = idx_q[AW-1:0];
        list_wdata = list_rdata;
        list_raddr = idx_q[AW-1:0] + AW'(2);
        idx_d      = idx_q + cac_pkg::CNT_W'(1);
      end

      cac_pkg::ST_LAST: begin
        live_d = live_q - cac_pkg::CNT_W'(1);
        if (live_q == cac_pkg::CNT_W'(1)) begin
          fp_d = cac_pkg::PTR_W'(reserve_q);
        end else begin
          list_raddr = live_q[AW-1:0] - AW'(2);
        end
      end

      cac_pkg::ST_LAST_ID: begin
        region_raddr = last_slot;
      end

      cac_pkg::ST_LAST_SUM: begin
        fp_d = start_rdata + cac_pkg::PTR_W'(size_rdata);
      end

      cac_pkg::ST_COMPACT: begin
        // Stage 1: fetch the list entry.
        if (idx_q < live_q) begin
          list_raddr = idx_q[AW-1:0];
          idx_d      = idx_q + cac_pkg::CNT_W'(1);
          v1_d       = 1'b1;
        end
        // Stage 2: fetch the region entry of that id.
        if (v1_q) begin
          region_raddr = last_slot;
          slot_d       = last_slot;
        end
        v2_d = v1_q;
        // Stage 3: place the region, keep its size, and advance the packing pointer.
        if (v2_q) begin
          region_we    = 1'b1;
          region_waddr = slot_q;
          region_wdata = {size_rdata, next_q};
          next_d       = next_q + cac_pkg::PTR_W'(size_rdata);
        end
        if (walk_done) begin
          fp_d = next_q;
        end
      end

      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Stores
  // --------------------------------------------------------------------------
  cac_ram #(
    .DATA_W (cac_pkg::ID_W),
    .ADDR_W (AW)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (list_wdata),
    .raddr_i (list_raddr),
    .rdata_o (list_rdata)
  );

  cac_ram #(
    .DATA_W (REGION_W),
    .ADDR_W (AW)
  ) u_region_ram (
    .clk_i   (clk_i),
    .we_i    (region_we),
    .waddr_i (region_waddr),
    .wdata_i (region_wdata),
    .raddr_i (region_raddr),
    .rdata_o (region_rdata)
  );

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cac_pkg::ST_IDLE;
      reserve_q   <= cac_pkg::RSV_W'(cac_pkg::RESERVE_RESET);
      id_q        <= '0;
      live_q      <= '0;
      fp_q        <= cac_pkg::PTR_W'(cac_pkg::RESERVE_RESET);
      idx_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (os_reserve_we_i) begin
        reserve_q <= os_reserve_i;
      end
      id_q   <= id_d;
      live_q <= live_d;
      fp_q   <= fp_d;
      idx_q  <= idx_d;
      v1_q   <= v1_d;
      v2_q   <= v2_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= cac_pkg::cmd_e'(command_i);
      size_q <= region_size_i;
      pos_q  <= victim_position_i;
    end
    next_q       <= next_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_addr_q   <= res_addr_d;
    // Hold the result until the consumer takes it.
    if (load_out) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_addr_q   <= res_addr_q;
      out_free_q   <= fp_q[cac_pkg::ADDR_W-1:0];
      out_count_q  <= live_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign region_id_o      = out_id_q;
  assign region_address_o = out_addr_q;
  assign next_free_o      = out_free_q;
  assign active_count_o   = out_count_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CAC_ASSERT(a_live_bound, clk_i, rst_ni, live_q <= cac_pkg::CNT_W'(cac_pkg::MAX_ENTRIES))
  `CAC_ASSERT(a_live_le_ids, clk_i, rst_ni, live_q <= id_q)
  `CAC_ASSERT_NEXT(a_accept_decode, clk_i, rst_ni, in_accept, state_q == cac_pkg::ST_DECODE)
  `CAC_ASSERT_NEXT(a_done_loads, clk_i, rst_ni, load_out, out_valid_q)
  `CAC_ASSERT(a_shift_in_list, clk_i, rst_ni, (state_q != cac_pkg::ST_SHIFT) || shift_more)
  `CAC_ASSERT_NEXT(a_walk_pipe, clk_i, rst_ni, v1_q && (state_q == cac_pkg::ST_COMPACT), v2_q)

endmodule

`default_nettype wire

// ----- tb/alloc_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alloc_tb_pkg
// Result type and scoreboard for the contiguous allocator testbench. The
// scoreboard keeps its own copy of the region list, sizes, starts and free
// pointer, predicts one result per accepted command and checks results in
// order.
// ----------------------------------------------------------------------------
package alloc_tb_pkg;

  import cac_pkg::*;

  // Command code 3 has no meaning; the block answers it without any change.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN  = 2'd3;
  localparam int unsigned      REPORT_LIMIT = 10;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     id;
    logic [ADDR_W-1:0]   addr;
    logic [ADDR_W-1:0]   next_free;
    logic [CNT_W-1:0]    count;
  } alloc_result_t;

  class alloc_checker;
    logic [RSV_W-1:0]  reserve;
    logic [ID_W-1:0]   order [MAX_ENTRIES];
    logic [SIZE_W-1:0] sizes [MAX_ENTRIES];
    logic [31:0]       starts [MAX_ENTRIES];
    logic [31:0]       free_ptr;
    logic [31:0]       ids_issued;
    logic [31:0]       live;
    alloc_result_t     pending_results[$];
    int unsigned       mismatches;

    function new();
      reserve    = RSV_W'(RESERVE_RESET);
      free_ptr   = 32'(RESERVE_RESET);
      ids_issued = '0;
      live       = '0;
      mismatches = 0;
    endfunction

    function void set_reserve(logic [RSV_W-1:0] value);
      reserve = value;
    endfunction

    function int unsigned live_regions();
      return live;
    endfunction

    function int unsigned issued_ids();
      return ids_issued;
    endfunction

    function int unsigned free_pointer();
      return free_ptr;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    // Apply one accepted command to the shadow state and queue its result.
    function void note_command(logic [CMD_W-1:0] cmd, logic [SIZE_W-1:0] size,
                               logic [POS_W-1:0] pos);
      alloc_result_t r;
      logic [31:0]   slot;
      logic [31:0]   run;
      r.cmd    = cmd;
      r.status = STS_OK;
      r.id     = '0;
      r.addr   = '0;
      case (cmd)
        CMD_ALLOC: begin
          // Memory bound is checked before the id store.
          if (free_ptr + size > MEMORY_UNITS) begin
            r.status = STS_NO_MEM;
          end else if (ids_issued >= MAX_ENTRIES || live >= MAX_ENTRIES) begin
            r.status = STS_ID_FULL;
          end else begin
            ids_issued  = ids_issued + 1;
            slot        = ids_issued - 1;
            sizes[slot]  = size;
            starts[slot] = free_ptr;
            order[live] = ids_issued[ID_W-1:0];
            live        = live + 1;
            r.id        = ids_issued[ID_W-1:0];
            r.addr      = free_ptr[ADDR_W-1:0];
            free_ptr    = free_ptr + size;
          end
        end
        CMD_FREE: begin
          if (live == 0) begin
            free_ptr = reserve;
            r.status = STS_NONE_ACTIVE;
          end else if (pos >= live) begin
            r.status = STS_BAD_POS;
          end else begin
            r.id = order[pos];
            for (int i = pos; i + 1 < live; i++) order[i] = order[i + 1];
            live = live - 1;
            if (live > 0) begin
              slot     = order[live - 1] - 1;
              free_ptr = starts[slot] + sizes[slot];
            end else begin
              free_ptr = reserve;
            end
          end
        end
        CMD_COMPACT: begin
          run = reserve;
          for (int i = 0; i < live; i++) begin
            slot         = order[i] - 1;
            starts[slot] = run;
            run          = run + sizes[slot];
          end
          free_ptr = run;
        end
        default: begin
        end
      endcase
      r.next_free = free_ptr[ADDR_W-1:0];
      r.count     = live[CNT_W-1:0];
      pending_results.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result: status %0d id %0d addr %0d next %0d count %0d",
                   $realtime, got.status, got.id, got.addr, got.next_free, got.count);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.id !== want.id || got.addr !== want.addr ||
          got.next_free !== want.next_free || got.count !== want.count) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: mismatch on command %0d", $realtime, want.cmd);
          $display("  expected: status %0d id %0d addr %0d next %0d count %0d",
                   want.status, want.id, want.addr, want.next_free, want.count);
          $display("  actual:   status %0d id %0d addr %0d next %0d count %0d",
                   got.status, got.id, got.addr, got.next_free, got.count);
        end
      end
    endfunction
  endclass

endpackage

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives allocate, free, compact and unknown commands into the contiguous
// allocator under random sender gaps and receiver stalls, and checks every
// result against a scoreboard that tracks the region list on its own.
// ----------------------------------------------------------------------------
module tb;

  import cac_pkg::*;
  import alloc_tb_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned RESET_CYCLES   = 11;

  logic                clk_i;
  logic                rst_ni;
  logic                os_reserve_we_i;
  logic [RSV_W-1:0]    os_reserve_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [CMD_W-1:0]    command_i;
  logic [SIZE_W-1:0]   region_size_i;
  logic [POS_W-1:0]    victim_position_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [STATUS_W-1:0] status_o;
  logic [ID_W-1:0]     region_id_o;
  logic [ADDR_W-1:0]   region_address_o;
  logic [ADDR_W-1:0]   next_free_o;
  logic [CNT_W-1:0]    active_count_o;

  alloc_checker board;
  int           burst_left;
  int unsigned  idle_cycles;

  contiguous_allocator_compaction_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .os_reserve_we_i   (os_reserve_we_i),
    .os_reserve_i      (os_reserve_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .region_size_i     (region_size_i),
    .victim_position_i (victim_position_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .region_id_o       (region_id_o),
    .region_address_o  (region_address_o),
    .next_free_o       (next_free_o),
    .active_count_o    (active_count_o)
  );

  // 12 ns period clock.
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Receiver: segments of random length, each with its own stall density.
  // A density of zero gives long stretches of free flow.
  initial begin
    int seg_len;
    int pct;
    out_stall_i = 1'b0;
    forever begin
      seg_len = $urandom_range(20, 200);
      case ($urandom_range(3))
        0: pct = 0;
        1: pct = 25;
        2: pct = 50;
        default: pct = 85;
      endcase
      repeat (seg_len) begin
        @(negedge clk_i);
        out_stall_i <= ($urandom_range(99) < pct);
      end
    end
  end

  // Check every result item taken at a rising edge.
  always @(posedge clk_i) begin : result_monitor
    alloc_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.cmd       = '0;
      got.status    = status_o;
      got.id        = region_id_o;
      got.addr      = region_address_o;
      got.next_free = next_free_o;
      got.count     = active_count_o;
      board.check_result(got);
    end
  end

  // Count cycles in which neither channel moves an item.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one command item, hold it until taken, then advance the sender's
  // burst pattern: either keep valid high for the next item or drop it for a gap.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [SIZE_W-1:0] size,
                              input logic [POS_W-1:0] pos);
    int gap;
    @(negedge clk_i);
    in_valid_i        <= 1'b1;
    command_i         <= cmd;
    region_size_i     <= size;
    victim_position_i <= pos;
    do @(posedge clk_i); while (in_stall_o);
    board.note_command(cmd, size, pos);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 15);
    end
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reserve(input logic [RSV_W-1:0] value);
    wait_idle();
    @(negedge clk_i);
    os_reserve_we_i <= 1'b1;
    os_reserve_i    <= value;
    @(posedge clk_i);
    board.set_reserve(value);
    @(negedge clk_i);
    os_reserve_we_i <= 1'b0;
  endtask

  // Random command mix. Frees mostly hit a live position so the list
  // shifts; the rest use random positions over all position bits.
  task automatic run_mix(input int count);
    int               pick;
    int               live;
    logic [SIZE_W-1:0] size;
    logic [POS_W-1:0]  pos;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      live = board.live_regions();
      pos  = POS_W'($urandom);
      size = SIZE_W'($urandom);
      if (pick < 48) begin
        case ($urandom_range(19))
          0:             size = '0;
          1, 2, 3:       size = SIZE_W'($urandom_range(41, 256));
          4, 5, 6:       size = SIZE_W'($urandom_range(2047));
          default:       size = SIZE_W'($urandom_range(1, 40));
        endcase
        send_command(CMD_ALLOC, size, pos);
      end else if (pick < 82) begin
        if (live > 0 && $urandom_range(9) != 0) pos = POS_W'($urandom_range(live - 1));
        send_command(CMD_FREE, size, pos);
      end else if (pick < 94) begin
        send_command(CMD_COMPACT, size, pos);
      end else begin
        send_command(CMD_UNKNOWN, size, pos);
      end
    end
  endtask

  initial begin
    int guard;
    int pick;

    // Drive every input to a known value, then hold reset.
    board             = new();
    rst_ni            = 1'b0;
    os_reserve_we_i   = 1'b0;
    os_reserve_i      = '0;
    in_valid_i        = 1'b0;
    command_i         = '0;
    region_size_i     = '0;
    victim_position_i = '0;
    burst_left        = 0;
    idle_cycles       = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // Directed part at the reset reserve.
    send_command(CMD_FREE, '0, '0);              // free with nothing active
    send_command(CMD_COMPACT, '0, '0);           // compact of an empty list
    send_command(CMD_UNKNOWN, '1, '1);           // unknown command, all ones
    send_command(CMD_ALLOC, '0, '0);             // zero-size region
    send_command(CMD_ALLOC, '1, '0);             // far past the memory end
    send_command(CMD_ALLOC, SIZE_W'(MEMORY_UNITS), '0);
    send_command(CMD_ALLOC, 11'd100, '0);
    send_command(CMD_ALLOC, 11'd200, '0);
    send_command(CMD_FREE, '0, '1);              // bad position, all ones
    send_command(CMD_FREE, '0, POS_W'(board.live_regions()));  // one past the end
    send_command(CMD_FREE, '0, 9'd1);            // middle of the list
    send_command(CMD_COMPACT, '0, '0);
    // Fill memory exactly to the end, then take an empty region at the end.
    send_command(CMD_ALLOC, SIZE_W'(MEMORY_UNITS - board.free_pointer()), '0);
    send_command(CMD_ALLOC, '0, '0);
    send_command(CMD_ALLOC, 11'd1, '0);          // one unit too many
    send_command(CMD_FREE, '0, '0);              // head of the list
    send_command(CMD_FREE, '0, POS_W'(board.live_regions() - 1));  // tail
    while (board.live_regions() > 0) send_command(CMD_FREE, '0, '0);
    send_command(CMD_FREE, '0, '0);              // empty again
    send_command(CMD_ALLOC, 11'd1, '0);
    send_command(CMD_COMPACT, '1, '1);
    send_command(CMD_UNKNOWN, '0, '0);

    // Random phases over several reserve settings, extremes included.
    write_reserve('0);
    send_command(CMD_COMPACT, '0, '0);
    run_mix(250);
    write_reserve(RSV_W'(MEMORY_UNITS));
    run_mix(80);
    write_reserve(RSV_W'($urandom_range(100, 700)));
    send_command(CMD_COMPACT, '0, '0);
    run_mix(250);
    write_reserve(RSV_W'(RESERVE_RESET));
    run_mix(120);

    // Use up the id store with mostly empty regions. With a zero reserve a
    // compact brings the free pointer back inside memory.
    write_reserve('0);
    send_command(CMD_COMPACT, '0, '0);
    guard = 0;
    while (board.issued_ids() < MAX_ENTRIES && guard < 2000) begin
      guard++;
      pick = $urandom_range(99);
      if (board.free_pointer() > MEMORY_UNITS)
        send_command(CMD_COMPACT, '0, '0);
      else if (pick < 12 && board.live_regions() > 0)
        send_command(CMD_FREE, '0, POS_W'($urandom_range(board.live_regions() - 1)));
      else if (pick < 20 && board.free_pointer() < MEMORY_UNITS)
        send_command(CMD_ALLOC, 11'd1, '0);
      else
        send_command(CMD_ALLOC, '0, POS_W'($urandom));
    end
    // Id store exhausted: every allocate is now refused.
    repeat (4) send_command(CMD_ALLOC, '0, '0);
    send_command(CMD_ALLOC, '1, '0);
    send_command(CMD_FREE, '0, '0);              // long shift over a deep list
    send_command(CMD_ALLOC, '0, '0);
    send_command(CMD_COMPACT, '0, '0);

    // Highest reserve values, with regions still live.
    write_reserve('1);
    send_command(CMD_COMPACT, '0, '0);
    send_command(CMD_ALLOC, '0, '0);
    send_command(CMD_FREE, '0, POS_W'(board.live_regions() - 1));
    send_command(CMD_FREE, '0, '0);
    send_command(CMD_FREE, '0, '1);
    write_reserve(RSV_W'(MEMORY_UNITS));
    send_command(CMD_COMPACT, '0, '0);
    run_mix(20);

    // Let the last results drain, then judge the run.
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
